// File: rtl/windowed_average_voltage_meter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed average voltage meter
// Shared concurrent-assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_AVERAGE_VOLTAGE_METER_DEFINES_SVH
`define WINDOWED_AVERAGE_VOLTAGE_METER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define WAVM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define WAVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/wavm_pkg.sv
// ----------------------------------------------------------------------------
// wavm_pkg
// Widths, reset values, register map and payload types of the meter.
// ----------------------------------------------------------------------------
`default_nettype none

package wavm_pkg;

   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned DIV_W      = 32;
   localparam int unsigned DIVISOR_W  = 16;
   localparam int unsigned STEP_CNT_W = 5;
   localparam int unsigned WINDOW_DEF = 128;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [1:0]          reg_index_type;

   localparam reg_index_type REG_SCALE_MUL       = 2'd0;
   localparam reg_index_type REG_SCALE_DIV       = 2'd1;
   localparam reg_index_type REG_REPORT_INTERVAL = 2'd2;

   localparam logic [15:0] SCALE_MUL_RST       = 16'd29300;
   localparam logic [15:0] SCALE_DIV_RST       = 16'd32740;
   localparam logic [7:0]  REPORT_INTERVAL_RST = 8'd30;

   localparam sample_type SAMPLE_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// File: rtl/wavm_intf.sv
// ----------------------------------------------------------------------------
// wavm request and response channels
// Valid/ready channels carrying a sample in and a reading out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wavm_req_if;
   logic                 valid;
   logic                 ready;
   wavm_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface wavm_rsp_if;
   logic                 valid;
   logic                 ready;
   wavm_pkg::sample_type mean_value;
   wavm_pkg::sample_type scaled_reading;

   modport source (output valid, output mean_value, output scaled_reading, input ready);
   modport sink   (input valid, input mean_value, input scaled_reading, output ready);
endinterface

`default_nettype wire

// File: rtl/windowed_average_voltage_meter.sv
// Moving-average voltage meter. Each request carries one 16-bit sample, which
// replaces the oldest of the last WINDOW samples held in a ring memory; a
// running sum tracks the ring. WINDOW must be a power of two, so the mean is
// the running sum shifted right. Slots not yet written since reset read as zero, so early means count
// the empty slots as zeros. Every report_interval samples one response is
// produced: the window mean and mean*scale_mul/scale_div saturated to 16 bits.
// A request that produces no response reads the ring slot, then writes it
// back. A reporting request goes on, with any response stall at the end:
// the update cycle forms the mean, a 16x16 multiply follows, a 32-step serial
// divider applies the gain, and the done state loads the response register.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// windowed_average_voltage_meter
// Ring-buffer moving average with scaled reading and APB register port.
// ----------------------------------------------------------------------------
`default_nettype none

`include "windowed_average_voltage_meter_defines.svh"

module windowed_average_voltage_meter #(
   parameter int unsigned WINDOW = wavm_pkg::WINDOW_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   wavm_req_if.sink                                req_if,
   wavm_rsp_if.source                              rsp_if,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [wavm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [wavm_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [wavm_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                    pready
);

   localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned SUM_W  = wavm_pkg::SAMPLE_W + SLOT_W;
   localparam int unsigned DIV_W  = wavm_pkg::DIV_W;
   localparam int unsigned DVR_W  = wavm_pkg::DIVISOR_W;
   localparam int unsigned CNT_W  = wavm_pkg::STEP_CNT_W;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0]  STEP_LAST = CNT_W'(DIV_W - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_UPD  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_SDIV = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   // control state
   logic [2:0]        state_ff,     state_in;
   logic [SLOT_W-1:0] slot_ff,      slot_in;
   logic              wrapped_ff,   wrapped_in;
   logic [SUM_W-1:0]  sum_ff,       sum_in;
   logic [7:0]        count_ff,     count_in;
   logic [CNT_W-1:0]  step_ff,      step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       scale_mul_ff, scale_mul_in;
   logic [15:0]       scale_div_ff, scale_div_in;
   logic [7:0]        interval_ff,  interval_in;

   // datapath
   wavm_pkg::sample_type sample_ff,     sample_in;
   wavm_pkg::sample_type mean_ff,       mean_in;
   logic [DVR_W-1:0]     rem_ff,        rem_in;
   logic [DIV_W-1:0]     quo_ff,        quo_in;
   logic [DVR_W-1:0]     divisor_ff,    divisor_in;
   wavm_pkg::sample_type rsp_mean_ff,   rsp_mean_in;
   wavm_pkg::sample_type rsp_scaled_ff, rsp_scaled_in;

   // ring memory
   wavm_pkg::sample_type ring_mem [WINDOW];
   wavm_pkg::sample_type rd_data_ff;
   logic                 ring_we;

   logic                 req_take;
   logic                 csr_wr;
   wavm_pkg::reg_index_type csr_idx;
   wavm_pkg::sample_type old_sample;
   logic [7:0]           count_next;
   logic                 report;
   logic [DVR_W:0]       shifted;
   logic [DVR_W:0]       trial;
   logic                 take_sub;
   logic [DIV_W-1:0]     product;
   logic                 saturate;
   logic                 rsp_free;

   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.mean_value     = rsp_mean_ff;
   assign rsp_if.scaled_reading = rsp_scaled_ff;

   // register port
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   always_comb begin
      unique case (csr_idx)
         wavm_pkg::REG_SCALE_MUL:       prdata = 32'(scale_mul_ff);
         wavm_pkg::REG_SCALE_DIV:       prdata = 32'(scale_div_ff);
         wavm_pkg::REG_REPORT_INTERVAL: prdata = 32'(interval_ff);
         default:                       prdata = '0;
      endcase
   end

   always_comb begin
      scale_mul_in = scale_mul_ff;
      scale_div_in = scale_div_ff;
      interval_in  = interval_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            wavm_pkg::REG_SCALE_MUL:       scale_mul_in = pwdata[15:0];
            wavm_pkg::REG_SCALE_DIV:       scale_div_in = pwdata[15:0];
            wavm_pkg::REG_REPORT_INTERVAL: interval_in  = pwdata[7:0];
            default: ;
         endcase
      end
   end

   // slots not yet written since reset read as zero
   assign old_sample = wrapped_ff ? rd_data_ff : '0;
   assign count_next = count_ff + 8'd1;
   assign report     = (count_next >= interval_ff);

   // restoring divider step, one quotient bit per cycle
   assign shifted  = {rem_ff, quo_ff[DIV_W-1]};
   assign trial    = shifted - {1'b0, divisor_ff};
   assign take_sub = !trial[DVR_W];

   assign product  = 32'(mean_ff) * 32'(scale_mul_ff);
   assign saturate = (scale_div_ff == '0) || (quo_ff[DIV_W-1:16] != '0);

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      wrapped_in    = wrapped_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      sample_in     = sample_ff;
      mean_in       = mean_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      divisor_in    = divisor_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_scaled_in = rsp_scaled_ff;
      ring_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sample_in = req_if.sample;
               state_in  = ST_UPD;
            end
         end
         ST_UPD: begin
            ring_we = 1'b1;
            sum_in  = sum_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
            if (slot_ff == SLOT_LAST) begin
               slot_in    = '0;
               wrapped_in = 1'b1;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
            if (report) begin
               count_in = '0;
               // sum over the window divided by WINDOW
               mean_in  = sum_in[SUM_W-1:SLOT_W];
               state_in = ST_MUL;
            end else begin
               count_in = count_next;
               state_in = ST_IDLE;
            end
         end
         ST_SDIV: begin
            rem_in  = take_sub ? trial[DVR_W-1:0] : shifted[DVR_W-1:0];
            quo_in  = {quo_ff[DIV_W-2:0], take_sub};
            step_in = step_ff + CNT_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            rem_in     = '0;
            quo_in     = product;
            divisor_in = scale_div_ff;
            step_in    = '0;
            state_in   = ST_SDIV;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = mean_ff;
               rsp_scaled_in = saturate ? wavm_pkg::SAMPLE_MAX : quo_ff[15:0];
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         wrapped_ff   <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         scale_mul_ff <= wavm_pkg::SCALE_MUL_RST;
         scale_div_ff <= wavm_pkg::SCALE_DIV_RST;
         interval_ff  <= wavm_pkg::REPORT_INTERVAL_RST;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         wrapped_ff   <= wrapped_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         scale_mul_ff <= scale_mul_in;
         scale_div_ff <= scale_div_in;
         interval_ff  <= interval_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      mean_ff       <= mean_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      divisor_ff    <= divisor_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_scaled_ff <= rsp_scaled_in;
   end

   // read data is captured at the accept edge and used in the update cycle
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[slot_ff] <= sample_ff;
      end
      rd_data_ff <= ring_mem[slot_ff];
   end

   `WAVM_ASSERT_NEXT(a_accept_to_update, clock, reset, req_take, state_ff == ST_UPD, "accepted request did not enter update")
   `WAVM_ASSERT_SAME(a_slot_in_window, clock, reset, 1'b1, slot_ff <= SLOT_LAST, "ring slot beyond window")
   `WAVM_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "response raised outside done state")

endmodule

`default_nettype wire

// File: test/wavm_checker.sv
// ----------------------------------------------------------------------------
// wavm_checker
// Watches the sample, reading and register channels of the meter. It keeps
// its own copy of the window and gain settings, works out the reading each
// accepted sample should produce, and compares the readings that come out.
// ----------------------------------------------------------------------------
module wavm_checker
   import wavm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   wavm_req_if                        req,
   wavm_rsp_if                        rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic                  pready,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   input  wire logic [CSR_DATA_W-1:0] prdata,
   output int unsigned                pending,
   output int unsigned                failures,
   output int unsigned                readings_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WINDOW = WINDOW_DEF;

   typedef struct packed {
      sample_type mean_value;
      sample_type scaled_reading;
   } reading_type;

   sample_type  sample_ring [WINDOW];
   int unsigned write_slot;
   logic [31:0] window_sum;
   logic [7:0]  report_count;
   logic [15:0] scale_mul;
   logic [15:0] scale_div;
   logic [7:0]  report_interval;

   reading_type readings_due[$];
   int unsigned fail_total;
   int unsigned compared;

   // Folds one sample into the window; returns 1 when it triggers a reading.
   function automatic bit absorb_sample(input sample_type value, output reading_type reading);
      logic [31:0] product;
      logic [31:0] quotient;
      reading = '0;
      window_sum = window_sum - 32'(sample_ring[write_slot]) + 32'(value);
      sample_ring[write_slot] = value;
      write_slot = (write_slot + 1) % WINDOW;
      report_count = report_count + 8'd1;
      if (report_count < report_interval) begin
         return 1'b0;
      end
      report_count = '0;
      reading.mean_value = sample_type'(window_sum / WINDOW);
      product = 32'(reading.mean_value) * 32'(scale_mul);
      if (scale_div == '0) begin
         reading.scaled_reading = SAMPLE_MAX;
      end else begin
         quotient = product / 32'(scale_div);
         reading.scaled_reading = (quotient > 32'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                               : quotient[15:0];
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : monitor
      reading_type       want;
      reading_type       got;
      reg_index_type     index;
      logic [31:0]       reg_value;
      bit                mapped;
      if (reset) begin
         foreach (sample_ring[i]) sample_ring[i] = '0;
         write_slot      = 0;
         window_sum      = '0;
         report_count    = '0;
         scale_mul       = SCALE_MUL_RST;
         scale_div       = SCALE_DIV_RST;
         report_interval = REPORT_INTERVAL_RST;
         readings_due.delete();
         fail_total      = 0;
         compared        = 0;
      end else begin
         // register port: writes update the local copy, reads are compared
         if (psel && penable && pready) begin
            index  = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
            mapped = 1'b1;
            case (index)
               REG_SCALE_MUL:       reg_value = 32'(scale_mul);
               REG_SCALE_DIV:       reg_value = 32'(scale_div);
               REG_REPORT_INTERVAL: reg_value = 32'(report_interval);
               default: begin
                  reg_value = '0;
                  mapped    = 1'b0;
               end
            endcase
            if (pwrite) begin
               case (index)
                  REG_SCALE_MUL:       scale_mul       = pwdata[15:0];
                  REG_SCALE_DIV:       scale_div       = pwdata[15:0];
                  REG_REPORT_INTERVAL: report_interval = pwdata[7:0];
                  default: ;
               endcase
            end else if (mapped && prdata !== reg_value) begin
               $error("register %0d: expected %0d, got %0d", index, reg_value, prdata);
               fail_total++;
            end
         end

         if (rsp.valid && rsp.ready) begin
            got.mean_value     = rsp.mean_value;
            got.scaled_reading = rsp.scaled_reading;
            if (readings_due.size() == 0) begin
               $error("reading with none expected: mean_value %0d scaled_reading %0d",
                      got.mean_value, got.scaled_reading);
               fail_total++;
            end else begin
               want = readings_due.pop_front();
               compared++;
               if (got.mean_value !== want.mean_value) begin
                  $error("mean_value: expected %0d, got %0d",
                         want.mean_value, got.mean_value);
                  fail_total++;
               end
               if (got.scaled_reading !== want.scaled_reading) begin
                  $error("scaled_reading: expected %0d, got %0d",
                         want.scaled_reading, got.scaled_reading);
                  fail_total++;
               end
            end
         end

         if (req.valid && req.ready) begin
            if (absorb_sample(req.sample, want)) begin
               readings_due.push_back(want);
            end
         end
      end
      pending          <= readings_due.size();
      failures         <= fail_total;
      readings_checked <= compared;
   end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Windowed average voltage meter testbench
// Drives samples and register settings into the meter with random idle
// bursts on both channels; the checker predicts and compares every reading.
// ----------------------------------------------------------------------------
module testbench;
   import wavm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam reg_index_type REG_UNMAPPED = 2'd3;
   localparam int unsigned   RANDOM_ITEMS = 1000;
   localparam int unsigned   DRAIN_CYCLES = 80;

   logic clock;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int unsigned pending;
   int unsigned failures;
   int unsigned readings_checked;
   int unsigned samples_sent;
   int unsigned settings_used;

   bit          gaps_on;
   logic        stall_on;
   int unsigned stall_left;

   wavm_req_if req_bus ();
   wavm_rsp_if rsp_bus ();

   windowed_average_voltage_meter dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   wavm_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .psel             (csr_psel),
      .penable          (csr_penable),
      .pwrite           (csr_pwrite),
      .pready           (csr_pready),
      .paddr            (csr_paddr),
      .pwdata           (csr_pwdata),
      .prdata           (csr_prdata),
      .pending          (pending),
      .failures         (failures),
      .readings_checked (readings_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("tb: failure");
      $finish;
   end

   // response side: random stall bursts that hold ready low
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left    <= 0;
         rsp_bus.ready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
         stall_left    <= $urandom_range(1, 14);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // setup phase, then access phase held until pready, then the bus goes idle
   task automatic csr_access(input bit is_write, input reg_index_type index,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // writes all three registers (upper bits sometimes junk) and sometimes an unmapped one, then reads back
   task automatic configure(input logic [15:0] mul, input logic [15:0] div,
                            input logic [7:0] interval);
      logic [31:0] junk;
      junk = $urandom_range(0, 1) ? $urandom : 32'd0;
      csr_access(1'b1, REG_SCALE_MUL, {junk[15:0], mul});
      junk = $urandom_range(0, 1) ? $urandom : 32'd0;
      csr_access(1'b1, REG_SCALE_DIV, {junk[31:16], div});
      junk = $urandom_range(0, 1) ? $urandom : 32'd0;
      csr_access(1'b1, REG_REPORT_INTERVAL, {junk[23:0], interval});
      if ($urandom_range(0, 2) == 0) begin
         csr_access(1'b1, REG_UNMAPPED, $urandom);
      end
      csr_access(1'b0, REG_SCALE_MUL, '0);
      csr_access(1'b0, REG_SCALE_DIV, '0);
      csr_access(1'b0, REG_REPORT_INTERVAL, '0);
      settings_used++;
   endtask

   task automatic send_sample(input sample_type value);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid  <= 1'b0;
         req_bus.sample <= sample_type'($urandom);
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= value;
      do @(posedge clock); while (!req_bus.ready);
      samples_sent++;
   endtask

   // drop valid, wait for every reading due, then let the meter drain
   task automatic settle();
      req_bus.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned random_sent;
      int unsigned phase_len;
      int unsigned sample_style;
      logic [15:0] mul;
      logic [15:0] div;
      logic [7:0]  interval;
      sample_type  level;
      sample_type  value;
      bit          quiet;

      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      gaps_on        = 1'b1;
      stall_on       = 1'b1;
      samples_sent   = 0;
      settings_used  = 0;
      random_sent    = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values
      csr_access(1'b0, REG_SCALE_MUL, '0);
      csr_access(1'b0, REG_SCALE_DIV, '0);
      csr_access(1'b0, REG_REPORT_INTERVAL, '0);

      // large gain saturates; a reading every sample
      configure(16'hFFFF, 16'd1, 8'd1);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      send_sample(16'hAAAA);
      send_sample(16'h5555);
      send_sample(16'hFFFF);
      send_sample(16'h0001);
      settle();

      // divisor of zero
      configure(16'd29300, 16'd0, 8'd1);
      send_sample(16'hFFFF);
      send_sample(16'h8000);
      settle();

      // interval of zero acts as one; zero gain
      configure(16'd0, 16'hFFFF, 8'd0);
      send_sample(16'h7FFF);
      send_sample(16'hFFFF);
      settle();

      // lowering the interval below the running count fires on the next request
      configure(16'd1, 16'd1, 8'd8);
      repeat (5) send_sample(sample_type'($urandom));
      settle();
      configure(16'd1, 16'd1, 8'd3);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      settle();

      while (random_sent < RANDOM_ITEMS || readings_checked < 48) begin
         quiet = (random_sent >= RANDOM_ITEMS - 150);

         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: interval = 8'($urandom_range(1, 6));
            6, 7:             interval = 8'($urandom_range(7, 40));
            8:                interval = 8'($urandom_range(41, 255));
            default:          interval = $urandom_range(0, 1) ? 8'd0 : 8'd255;
         endcase
         case ($urandom_range(0, 5))
            0:       mul = 16'd0;
            1:       mul = 16'hFFFF;
            2, 3:    mul = 16'($urandom_range(1000, 40000));
            default: mul = 16'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0:       div = 16'd0;
            1:       div = 16'd1;
            2:       div = 16'hFFFF;
            3, 4, 5: div = 16'($urandom_range(1000, 65535));
            default: div = 16'($urandom);
         endcase
         configure(mul, div, interval);

         if (quiet) begin
            gaps_on = 1'b0;
            stall_on <= 1'b0;
         end else begin
            gaps_on = 1'($urandom_range(0, 1));
            stall_on <= 1'($urandom_range(0, 1));
         end

         phase_len    = $urandom_range(40, 120);
         sample_style = $urandom_range(0, 2);
         level        = sample_type'($urandom);
         repeat (phase_len) begin
            case (sample_style)
               // steady level with noise in the low bits
               0: value = {level[15:9], 9'($urandom)};
               1: begin
                  case ($urandom_range(0, 3))
                     0:       value = 16'h0000;
                     1:       value = 16'hFFFF;
                     2:       value = sample_type'(1) << $urandom_range(0, 15);
                     default: value = sample_type'($urandom);
                  endcase
               end
               default: value = sample_type'($urandom);
            endcase
            send_sample(value);
            random_sent++;
         end
         settle();
      end

      $display("summary: %0d samples over %0d register settings, %0d readings compared",
               samples_sent, settings_used, readings_checked);
      if (failures == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/wavm_pkg.sv
rtl/wavm_intf.sv
rtl/windowed_average_voltage_meter.sv
test/wavm_checker.sv
test/testbench.sv
